// ===== rtl/icps_pkg.sv =====
// Package for the IR carrier pulse segmenter: field widths, arithmetic constants,
// end codes and the job record handed from the period unit to the chunker.
// No dependencies.
package icps_pkg;

   // Field widths of the channels and the configuration register.
   localparam int unsigned DUR_BITS    = 24;
   localparam int unsigned FREQ_BITS   = 16;
   localparam int unsigned RELOAD_W    = 16;
   localparam int unsigned END_W       = 2;

   // Datapath widths: product plus rounding term, quotient and partial remainder.
   localparam int unsigned PROD_BITS   = DUR_BITS + FREQ_BITS;
   localparam int unsigned QUOT_BITS   = 21;
   localparam int unsigned REM_BITS    = 20;
   localparam int unsigned CNT_BITS    = 5;

   // Microseconds per second and the half used for round-half-up.
   localparam logic [QUOT_BITS-1:0] DIVISOR   = QUOT_BITS'(1000000);
   localparam logic [PROD_BITS-1:0] ROUND_ADD = PROD_BITS'(500000);

   // Largest period count the chunking registers can hold.
   localparam logic [QUOT_BITS-1:0] STATE_MAX = {QUOT_BITS{1'b1}};

   // Carrier frequency after reset.
   localparam logic [FREQ_BITS-1:0] FREQ_RESET = FREQ_BITS'(38000);

   // End codes.
   localparam logic [END_W-1:0] END_NONE   = 2'd0;
   localparam logic [END_W-1:0] END_PACKET = 2'd1;
   localparam logic [END_W-1:0] END_LAST   = 2'd2;
   localparam logic [END_W-1:0] END_RSVD   = 2'd3;

   // One converted timing, ready to be cut into reload words.
   typedef struct packed {
      logic [QUOT_BITS-1:0] periods;
      logic                 level;
      logic [END_W-1:0]     end_code;
   } seg_job_type;

endpackage

// ===== rtl/icps_if.sv =====
// Valid/ready channel interfaces for the IR carrier pulse segmenter.
// Depends on icps_pkg for the field widths.
interface icps_req_if;
   logic                                valid;
   logic                                ready;
   logic [icps_pkg::DUR_BITS-1:0]       duration_us;
   logic                                mark_level;
   logic [icps_pkg::END_W-1:0]          end_code;

   modport source (output valid, output duration_us, output mark_level, output end_code,
                   input ready);
   modport sink   (input valid, input duration_us, input mark_level, input end_code,
                   output ready);
endinterface

interface icps_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [icps_pkg::RELOAD_W-1:0]       reload_value;
   logic                                carrier_on;
   logic                                has_pulses;
   logic [icps_pkg::END_W-1:0]          end_flag;
   logic                                last;

   modport source (output valid, output reload_value, output carrier_on,
                   output has_pulses, output end_flag, output last, input ready);
   modport sink   (input valid, input reload_value, input carrier_on,
                   input has_pulses, input end_flag, input last, output ready);
endinterface

// ===== rtl/icps_period_calc.sv =====
// Bit-serial period unit: duration times frequency by shift-and-add, rounding,
// then restoring division by one million, one quotient bit per cycle.
// Depends on icps_pkg.
module icps_period_calc #(
   parameter int unsigned RELOAD_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [icps_pkg::DUR_BITS-1:0]   duration_us,
   input  logic                            mark_level,
   input  logic [icps_pkg::END_W-1:0]      end_code,
   input  logic [icps_pkg::FREQ_BITS-1:0]  carrier_freq_hz,
   output logic                            ready,
   output logic                            job_valid,
   output icps_pkg::seg_job_type           job,
   input  logic                            job_ready
);

   // Cap of the period count: sixteen full chunks, and no more than the state holds.
   localparam logic [63:0] CHUNK64 = 64'd1 << RELOAD_BITS;
   localparam logic [63:0] CAP16   = CHUNK64 * 64'd16;
   localparam logic [63:0] CAP64   =
      (CAP16 > 64'(icps_pkg::STATE_MAX)) ? 64'(icps_pkg::STATE_MAX) : CAP16;
   localparam logic [icps_pkg::QUOT_BITS-1:0] CAP = CAP64[icps_pkg::QUOT_BITS-1:0];

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ROUND,
      ST_DIV,
      ST_DONE
   } state_type;

   state_type                              state_ff, state_in;
   logic [icps_pkg::PROD_BITS-1:0]         acc_ff, acc_in;
   logic [icps_pkg::DUR_BITS-1:0]          dur_ff, dur_in;
   logic [icps_pkg::FREQ_BITS-1:0]         freq_sh_ff, freq_sh_in;
   logic [icps_pkg::REM_BITS-1:0]          rem_ff, rem_in;
   logic [icps_pkg::CNT_BITS-1:0]          cnt_ff, cnt_in;
   logic                                   level_ff, level_in;
   logic [icps_pkg::END_W-1:0]             end_ff, end_in;

   logic [icps_pkg::PROD_BITS-1:0]         mul_sum;
   logic [icps_pkg::PROD_BITS-1:0]         rnd_sum;
   logic [icps_pkg::QUOT_BITS-1:0]         div_trial;
   logic [icps_pkg::QUOT_BITS-1:0]         div_diff;
   logic                                   div_ge;
   logic [icps_pkg::QUOT_BITS-1:0]         quot;

   // One multiplier bit per cycle, most significant first.
   assign mul_sum = {acc_ff[icps_pkg::PROD_BITS-2:0], 1'b0}
                  + (freq_sh_ff[icps_pkg::FREQ_BITS-1] ?
                     icps_pkg::PROD_BITS'(dur_ff) : '0);

   // Half a unit before the division makes it round half up.
   assign rnd_sum = acc_ff + icps_pkg::ROUND_ADD;

   // One restoring division step: bring down a dividend bit and try the subtract.
   assign div_trial = {rem_ff, acc_ff[icps_pkg::PROD_BITS-1]};
   assign div_ge    = (div_trial >= icps_pkg::DIVISOR);
   assign div_diff  = div_trial - icps_pkg::DIVISOR;

   // Quotient bits collect at the bottom of the dividend register.
   assign quot = acc_ff[icps_pkg::QUOT_BITS-1:0];

   // Sequencer next state and datapath.
   always_comb begin
      state_in   = state_ff;
      acc_in     = acc_ff;
      dur_in     = dur_ff;
      freq_sh_in = freq_sh_ff;
      rem_in     = rem_ff;
      cnt_in     = cnt_ff;
      level_in   = level_ff;
      end_in     = end_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in   = ST_MUL;
               acc_in     = '0;
               dur_in     = duration_us;
               freq_sh_in = carrier_freq_hz;
               cnt_in     = icps_pkg::CNT_BITS'(icps_pkg::FREQ_BITS - 1);
               level_in   = mark_level;
               end_in     = (end_code == icps_pkg::END_RSVD) ? icps_pkg::END_LAST : end_code;
            end
         end
         ST_MUL: begin
            acc_in     = mul_sum;
            freq_sh_in = {freq_sh_ff[icps_pkg::FREQ_BITS-2:0], 1'b0};
            cnt_in     = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            // Top bits seed the remainder; the rest move up to be shifted in.
            rem_in   = icps_pkg::REM_BITS'(rnd_sum[icps_pkg::PROD_BITS-1:icps_pkg::QUOT_BITS]);
            acc_in   = {rnd_sum[icps_pkg::QUOT_BITS-1:0],
                        {(icps_pkg::PROD_BITS - icps_pkg::QUOT_BITS){1'b0}}};
            cnt_in   = icps_pkg::CNT_BITS'(icps_pkg::QUOT_BITS - 1);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in = div_ge ? div_diff[icps_pkg::REM_BITS-1:0]
                            : div_trial[icps_pkg::REM_BITS-1:0];
            acc_in = {acc_ff[icps_pkg::PROD_BITS-2:0], div_ge};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (job_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and datapath registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      acc_ff     <= acc_in;
      dur_ff     <= dur_in;
      freq_sh_ff <= freq_sh_in;
      rem_ff     <= rem_in;
      cnt_ff     <= cnt_in;
      level_ff   <= level_in;
      end_ff     <= end_in;
   end

   // Finished job with the period count saturated.
   assign ready         = (state_ff == ST_IDLE);
   assign job_valid     = (state_ff == ST_DONE);
   assign job.periods   = (quot > CAP) ? CAP : quot;
   assign job.level     = level_ff;
   assign job.end_code  = end_ff;

endmodule

// ===== rtl/icps_chunker.sv =====
// Chunker: cuts a period count into reload words of at most one chunk each and
// holds every result in an output register. Depends on icps_pkg and icps_if.
module icps_chunker #(
   parameter int unsigned RELOAD_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   job_valid,
   input  icps_pkg::seg_job_type  job,
   output logic                   job_ready,
   icps_rsp_if.source             rsp
);

   localparam int unsigned SEG_W = icps_pkg::QUOT_BITS + 1;
   // Chunk size, limited to what the period count can ever reach.
   localparam logic [63:0] CHUNK64 = 64'd1 << RELOAD_BITS;
   localparam logic [63:0] LIM64   =
      (CHUNK64 > (64'd1 << icps_pkg::QUOT_BITS)) ? (64'd1 << icps_pkg::QUOT_BITS) : CHUNK64;
   localparam logic [SEG_W-1:0] SEG_LIM = LIM64[SEG_W-1:0];

   logic                                  busy_ff, busy_in;
   logic [icps_pkg::QUOT_BITS-1:0]        rem_ff, rem_in;
   logic                                  level_ff, level_in;
   logic [icps_pkg::END_W-1:0]            end_ff, end_in;
   logic                                  out_valid_ff, out_valid_in;
   logic [icps_pkg::RELOAD_W-1:0]         reload_ff, reload_in;
   logic                                  carrier_ff, carrier_in;
   logic                                  pulses_ff, pulses_in;
   logic [icps_pkg::END_W-1:0]            end_flag_ff, end_flag_in;
   logic                                  last_ff, last_in;

   logic                                  slot_free;
   logic [SEG_W-1:0]                      rem_ext;
   logic [SEG_W-1:0]                      seg;
   logic [SEG_W-1:0]                      rem_after;
   logic [SEG_W-1:0]                      seg_m1;
   logic                                  fin;

   // The output register can take a result when empty or being drained.
   assign slot_free = !out_valid_ff || rsp.ready;

   // Next segment and what is left after it.
   assign rem_ext   = {1'b0, rem_ff};
   assign seg       = (rem_ext > SEG_LIM) ? SEG_LIM : rem_ext;
   assign rem_after = rem_ext - seg;
   assign seg_m1    = seg - 1'b1;
   assign fin       = (rem_after == '0);

   // Load a job, then emit one word per free output slot.
   always_comb begin
      busy_in      = busy_ff;
      rem_in       = rem_ff;
      level_in     = level_ff;
      end_in       = end_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      reload_in    = reload_ff;
      carrier_in   = carrier_ff;
      pulses_in    = pulses_ff;
      end_flag_in  = end_flag_ff;
      last_in      = last_ff;
      if (!busy_ff) begin
         if (job_valid) begin
            busy_in  = 1'b1;
            rem_in   = job.periods;
            level_in = job.level;
            end_in   = job.end_code;
         end
      end else if (slot_free) begin
         if (rem_ff == '0) begin
            // Empty timing: an end marker only if it carries an end code.
            busy_in      = 1'b0;
            out_valid_in = (end_ff != icps_pkg::END_NONE);
            reload_in    = '0;
            carrier_in   = 1'b0;
            pulses_in    = 1'b0;
            end_flag_in  = end_ff;
            last_in      = 1'b1;
         end else begin
            busy_in      = !fin;
            rem_in       = rem_after[icps_pkg::QUOT_BITS-1:0];
            out_valid_in = 1'b1;
            reload_in    = seg_m1[icps_pkg::RELOAD_W-1:0];
            carrier_in   = level_ff;
            pulses_in    = 1'b1;
            end_flag_in  = fin ? end_ff : icps_pkg::END_NONE;
            last_in      = fin;
         end
      end
   end

   // Control and payload registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
      rem_ff      <= rem_in;
      level_ff    <= level_in;
      end_ff      <= end_in;
      reload_ff   <= reload_in;
      carrier_ff  <= carrier_in;
      pulses_ff   <= pulses_in;
      end_flag_ff <= end_flag_in;
      last_ff     <= last_in;
   end

   assign job_ready        = !busy_ff;
   assign rsp.valid        = out_valid_ff;
   assign rsp.reload_value = reload_ff;
   assign rsp.carrier_on   = carrier_ff;
   assign rsp.has_pulses   = pulses_ff;
   assign rsp.end_flag     = end_flag_ff;
   assign rsp.last         = last_ff;

endmodule

// ===== rtl/ir_carrier_pulse_segmenter_top.sv =====
// IR carrier pulse segmenter. Each timing (duration in microseconds, level and end
// code) becomes round(duration * carrier_freq_hz / 1e6) carrier periods, halves
// rounded up, capped at 16 chunks, emitted as reload words of at most
// 2**RELOAD_BITS periods each, the end code on the last word; an empty timing with
// an end code yields one marker without pulses. Per timing, the period unit needs
// 16 shift-and-add multiply steps, a rounding add, 21 restoring divide steps and a
// handoff, and takes the next only after that handoff; the chunker produces
// one word per cycle while the consumer takes them, overlapping the next conversion.
// The frequency register resets to 38000 Hz and may be written only while idle.
module ir_carrier_pulse_segmenter_top #(
   parameter int unsigned RELOAD_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   icps_req_if.sink                        req_chan,
   icps_rsp_if.source                      rsp_chan,
   input  logic                            csr_wr_en,
   input  logic [icps_pkg::FREQ_BITS-1:0]  csr_wr_data
);

   logic [icps_pkg::FREQ_BITS-1:0]  freq_ff, freq_in;
   logic                            calc_ready;
   logic                            req_accept;
   logic                            job_valid;
   logic                            job_ready;
   icps_pkg::seg_job_type           job;

   // Carrier frequency register.
   assign freq_in = csr_wr_en ? csr_wr_data : freq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         freq_ff <= icps_pkg::FREQ_RESET;
      end else begin
         freq_ff <= freq_in;
      end
   end

   // A transaction is taken whenever the period unit is free.
   assign req_chan.ready = calc_ready;
   assign req_accept     = req_chan.valid && calc_ready;

   icps_period_calc #(
      .RELOAD_BITS (RELOAD_BITS)
   ) u_calc (
      .clock           (clock),
      .reset           (reset),
      .start           (req_accept),
      .duration_us     (req_chan.duration_us),
      .mark_level      (req_chan.mark_level),
      .end_code        (req_chan.end_code),
      .carrier_freq_hz (freq_ff),
      .ready           (calc_ready),
      .job_valid       (job_valid),
      .job             (job),
      .job_ready       (job_ready)
   );

   icps_chunker #(
      .RELOAD_BITS (RELOAD_BITS)
   ) u_chunker (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job       (job),
      .job_ready (job_ready),
      .rsp       (rsp_chan)
   );

   // A marker without pulses is always the final result and carries an end code.
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.has_pulses |->
         rsp_chan.last && (rsp_chan.end_flag != icps_pkg::END_NONE))
      else $error("end marker without end code or not final");

   // End codes ride only on the final result of a timing.
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (rsp_chan.end_flag != icps_pkg::END_NONE) |-> rsp_chan.last)
      else $error("end code on a non-final result");

   // The reserved end code is never emitted.
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.end_flag != icps_pkg::END_RSVD))
      else $error("reserved end code emitted");

   // After a transaction is taken the period unit is busy.
   assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> !req_chan.ready)
      else $error("input taken while period unit busy");

endmodule
